// ===== rtl/yrfc_pkg.sv =====
// shared types, constants and angle table for the yaw footprint corner block
package yrfc_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN       = 24;
  localparam int NUM_STG       = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int STG_W         = $clog2(TAB_LEN);

  // datapath widths
  localparam int VEC_W  = 37;
  localparam int ROT_W  = 33;
  localparam int TRIG_W = ROT_W - 14;
  localparam int PROD_W = 33 + TRIG_W;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic [1:0] LAST_IDX = 2'd3;

  // rotating cordic start value, gain 0.607252935 in Q3.30
  localparam logic signed [ROT_W-1:0] GAIN_Q30 = ROT_W'(652032874);

  // atan(2^-i) as a fraction of a turn scaled by 2^32
  localparam logic [31:0] TURN_ATAN [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [15:0]        size_x;
    logic [15:0]        size_z;
    logic [15:0]        scale_x;
    logic [15:0]        scale_z;
    logic signed [23:0] position_x;
    logic signed [23:0] position_z;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] corner_x;
    logic signed [23:0] corner_z;
    logic [1:0]         corner_index;
    logic               last_corner;
  } out_req_t;

  // vectoring cell state
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [ANGLE_BITS-1:0]   z;
    logic                    zero;
  } vec_t;

  // rotating cell state
  typedef struct packed {
    logic signed [ROT_W-1:0]    x;
    logic signed [ROT_W-1:0]    y;
    logic signed [ANGLE_BITS:0] z;
    logic                       flip;
  } rot_t;

  // per-object data riding alongside the cordic chains
  typedef struct packed {
    logic [31:0]        hx;
    logic [31:0]        hz;
    logic signed [23:0] px;
    logic signed [23:0] pz;
  } side_t;

  // stage angle rounded to ANGLE_BITS
  function automatic logic [ANGLE_BITS-1:0] stage_angle(input logic [STG_W-1:0] idx);
    logic [32:0] t;
    t = {1'b0, TURN_ATAN[idx]} + (33'd1 << (31 - ANGLE_BITS));
    return t[32-ANGLE_BITS +: ANGLE_BITS];
  endfunction

endpackage

// ===== rtl/yaw_rotated_footprint_corners_core.sv =====
// top level: yaw extraction, sin/cos, corner rotation and corner serializer
// Takes one object request per cycle while in_stall_o is low, into a pipeline of
// 2*CORDIC_STAGES+5 register stages (two rows of cordic cells, vectoring then
// rotating) and emits four corner requests per object, one per cycle while the output
// is not stalled, through the single corner output port. The whole pipeline advances
// together and holds while its last stage waits on a busy corner serializer.
module yaw_rotated_footprint_corners_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  yrfc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output yrfc_pkg::out_req_t out_req_o
);

  localparam int N    = yrfc_pkg::NUM_STG;
  localparam int AB   = yrfc_pkg::ANGLE_BITS;
  localparam int VW   = yrfc_pkg::VEC_W;
  localparam int RW   = yrfc_pkg::ROT_W;
  localparam int TW   = yrfc_pkg::TRIG_W;
  localparam int PW   = yrfc_pkg::PROD_W;
  localparam int AW   = yrfc_pkg::ACC_W;
  localparam int L    = 2 * N + 5;
  localparam int TRS  = 2 * N + 3;

  localparam logic signed [VW-1:0] ONE_Q28  = VW'(1) << 28;
  localparam logic [AB-1:0]        HALF_U   = AB'(1) << (AB - 1);
  localparam logic signed [AB:0]   HALF_S   = (AB + 1)'(1) << (AB - 1);
  localparam logic signed [AB:0]   QUART_S  = (AB + 1)'(1) << (AB - 2);
  localparam logic signed [RW-1:0] RND_TRIG = RW'(1) << 13;
  localparam logic signed [AW-1:0] RND_OUT  = AW'(1) << 24;
  localparam logic signed [AW-26:0] SAT_HI  = (AW - 25)'(8388607);
  localparam logic signed [AW-26:0] SAT_LO  = -(AW - 25)'(8388608);

  logic              adv;
  logic [L-1:0]      vld_q;
  yrfc_pkg::side_t   side_q [L];

  // pipeline moves when the last stage is empty or the serializer takes it
  logic ser_load;
  assign adv        = !vld_q[L-1] || ser_load;
  assign in_stall_o = !adv;

  // valid and side data shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].hx <= 32'(in_req_i.size_x) * 32'(in_req_i.scale_x);
      side_q[0].hz <= 32'(in_req_i.size_z) * 32'(in_req_i.scale_z);
      side_q[0].px <= in_req_i.position_x;
      side_q[0].pz <= in_req_i.position_z;
    end
  end

  for (genvar j = 1; j < L; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) side_q[j] <= side_q[j-1];
    end
  end

  // quaternion products
  logic signed [31:0] wy_q, xz_q, yy_q, zz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wy_q <= in_req_i.rot_w * in_req_i.rot_y;
      xz_q <= in_req_i.rot_x * in_req_i.rot_z;
      yy_q <= in_req_i.rot_y * in_req_i.rot_y;
      zz_q <= in_req_i.rot_z * in_req_i.rot_z;
    end
  end

  // atan2 operands and half-turn pre-rotation
  logic signed [VW-1:0] num, den;
  yrfc_pkg::vec_t       vec [N+1];
  yrfc_pkg::vec_t       prep_d;
  always_comb begin
    num = (VW'(wy_q) + VW'(xz_q)) <<< 1;
    den = ONE_Q28 - ((VW'(yy_q) + VW'(zz_q)) <<< 1);
    prep_d.zero = (num == '0) && (den == '0);
    if (den < 0) begin
      prep_d.x = -den;
      prep_d.y = -num;
      prep_d.z = HALF_U;
    end else begin
      prep_d.x = den;
      prep_d.y = num;
      prep_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) vec[0] <= prep_d;
  end

  // vectoring row
  for (genvar k = 0; k < N; k++) begin : g_vec
    yrfc_vec_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(yrfc_pkg::STG_W'(k)),
      .cell_i (vec[k]),
      .cell_o (vec[k+1])
    );
  end

  // fold yaw into the right half plane for the rotating row
  yrfc_pkg::rot_t rot [N+1];
  yrfc_pkg::rot_t rprep_d;
  logic [AB-1:0]  yaw;
  logic signed [AB:0] zs;
  always_comb begin
    yaw = vec[N].zero ? '0 : vec[N].z;
    zs  = signed'({yaw[AB-1], yaw});
    rprep_d.x    = yrfc_pkg::GAIN_Q30;
    rprep_d.y    = '0;
    rprep_d.flip = (zs > QUART_S) || (zs < -QUART_S);
    if (rprep_d.flip) begin
      rprep_d.z = (zs > 0) ? zs - HALF_S : zs + HALF_S;
    end else begin
      rprep_d.z = zs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) rot[0] <= rprep_d;
  end

  // rotating row
  for (genvar k = 0; k < N; k++) begin : g_rot
    yrfc_rot_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(yrfc_pkg::STG_W'(k)),
      .cell_i (rot[k]),
      .cell_o (rot[k+1])
    );
  end

  // undo fold and round cos/sin to Q.16
  logic signed [RW-1:0] xr, yr, xsum, ysum;
  logic signed [TW-1:0] cos_q, sin_q;
  always_comb begin
    xr   = rot[N].flip ? -rot[N].x : rot[N].x;
    yr   = rot[N].flip ? -rot[N].y : rot[N].y;
    xsum = xr + RND_TRIG;
    ysum = yr + RND_TRIG;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q <= xsum[14 +: TW];
      sin_q <= ysum[14 +: TW];
    end
  end

  // half extent times cos/sin
  logic signed [PW-1:0] hxc_q, hxs_q, hzc_q, hzs_q;
  logic signed [32:0]   hxe, hze;
  assign hxe = signed'({1'b0, side_q[TRS].hx});
  assign hze = signed'({1'b0, side_q[TRS].hz});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hxc_q <= hxe * cos_q;
      hxs_q <= hxe * sin_q;
      hzc_q <= hze * cos_q;
      hzs_q <= hze * sin_q;
    end
  end

  // corner serializer
  logic signed [PW-1:0] s_hxc_q, s_hxs_q, s_hzc_q, s_hzs_q;
  logic signed [23:0]   s_px_q, s_pz_q;
  logic                 busy_q;
  logic [1:0]           cnt_q;
  logic                 out_vld_q;
  yrfc_pkg::out_req_t   out_q, corner_d;
  logic                 slot_free;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign ser_load  = !busy_q || (slot_free && (cnt_q == yrfc_pkg::LAST_IDX));

  function automatic logic signed [23:0] finish(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0]  t;
    logic signed [AW-26:0] v;
    t = acc + RND_OUT;
    v = t[AW-1:25];
    if (v > SAT_HI) return 24'sh7fffff;
    if (v < SAT_LO) return 24'sh800000;
    return v[23:0];
  endfunction

  logic                 neg_x, neg_z;
  logic signed [AW-1:0] a_xc, a_xs, a_zc, a_zs, wx, wz;
  always_comb begin
    neg_x = (cnt_q == 2'd0) || (cnt_q == yrfc_pkg::LAST_IDX);
    neg_z = !cnt_q[1];
    a_xc  = neg_x ? -AW'(s_hxc_q) : AW'(s_hxc_q);
    a_xs  = neg_x ? -AW'(s_hxs_q) : AW'(s_hxs_q);
    a_zc  = neg_z ? -AW'(s_hzc_q) : AW'(s_hzc_q);
    a_zs  = neg_z ? -AW'(s_hzs_q) : AW'(s_hzs_q);
    wx    = (AW'(s_px_q) <<< 25) + a_xc - a_zs;
    wz    = (AW'(s_pz_q) <<< 25) + a_xs + a_zc;
    corner_d.corner_x     = finish(wx);
    corner_d.corner_z     = finish(wz);
    corner_d.corner_index = cnt_q;
    corner_d.last_corner  = (cnt_q == yrfc_pkg::LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (slot_free) out_vld_q <= busy_q;
      if (ser_load) begin
        busy_q <= vld_q[L-1];
        cnt_q  <= '0;
      end else if (slot_free) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && busy_q) out_q <= corner_d;
    if (ser_load) begin
      s_hxc_q <= hxc_q;
      s_hxs_q <= hxs_q;
      s_hzc_q <= hzc_q;
      s_hzs_q <= hzs_q;
      s_px_q  <= side_q[L-1].px;
      s_pz_q  <= side_q[L-1].pz;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  // checks
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last_corner == (out_req_o.corner_index == yrfc_pkg::LAST_IDX)))
    else $error("last corner flag mismatch");

  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (out_req_o.corner_index != yrfc_pkg::LAST_IDX))
    |=> (out_valid_o && (out_req_o.corner_index == $past(out_req_o.corner_index) + 2'd1)))
    else $error("corner requests not contiguous");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q[L-1] && busy_q))
    else $error("input stalled without a full pipeline");

endmodule

// ===== rtl/yrfc_vec_cell.sv =====
// one vectoring cordic iteration with its output register
module yrfc_vec_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [yrfc_pkg::STG_W-1:0]    stage_i,
  input  yrfc_pkg::vec_t                cell_i,
  output yrfc_pkg::vec_t                cell_o
);

  logic signed [yrfc_pkg::VEC_W-1:0] x, y, xs, ys;
  logic [yrfc_pkg::ANGLE_BITS-1:0]   ang;
  yrfc_pkg::vec_t                    cell_d, cell_q;

  // drive y toward zero
  always_comb begin
    x   = cell_i.x;
    y   = cell_i.y;
    xs  = x >>> stage_i;
    ys  = y >>> stage_i;
    ang = yrfc_pkg::stage_angle(stage_i);
    cell_d      = cell_i;
    if (y < 0) begin
      cell_d.x = x - ys;
      cell_d.y = y + xs;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = x + ys;
      cell_d.y = y - xs;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/yrfc_rot_cell.sv =====
// one rotating cordic iteration with its output register
module yrfc_rot_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [yrfc_pkg::STG_W-1:0]    stage_i,
  input  yrfc_pkg::rot_t                cell_i,
  output yrfc_pkg::rot_t                cell_o
);

  logic signed [yrfc_pkg::ROT_W-1:0]    x, y, xs, ys;
  logic signed [yrfc_pkg::ANGLE_BITS:0] z, ang;
  yrfc_pkg::rot_t                       cell_d, cell_q;

  // drive residual angle toward zero
  always_comb begin
    x   = cell_i.x;
    y   = cell_i.y;
    z   = cell_i.z;
    xs  = x >>> stage_i;
    ys  = y >>> stage_i;
    ang = signed'({1'b0, yrfc_pkg::stage_angle(stage_i)});
    cell_d = cell_i;
    if (z >= 0) begin
      cell_d.x = x - ys;
      cell_d.y = y + xs;
      cell_d.z = z - ang;
    end else begin
      cell_d.x = x + ys;
      cell_d.y = y - xs;
      cell_d.z = z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
